// ----- sv/sdpg_pkg.sv -----
// ----------------------------------------------------------------------------
// sdpg_pkg
// shared types and constants for the step/direction pulse generator
// ----------------------------------------------------------------------------
package sdpg_pkg;

    localparam int MAX_AXES     = 4;
    localparam int POS_W        = 32;
    localparam int FIELD_W      = 16;
    localparam int CFG_W        = MAX_AXES * FIELD_W;
    localparam int CFG_IDX_W    = 2;

    localparam int AXES_DEF     = 4;
    localparam int STEP_BIT_DEF = 17;
    localparam int COUNT_W_DEF  = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 64'h0001_0001_0001_0001;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_WIDTHS = 2'd0,
        CFG_DIR_SETUPS  = 2'd1,
        CFG_HOLD_TIMES  = 2'd2
    } t_cfg_idx;

    // per-axis timing settings, one 16-bit field each
    typedef struct packed {
        logic [FIELD_W-1:0] step_width;
        logic [FIELD_W-1:0] dir_setup;
        logic [FIELD_W-1:0] hold_time;
    } t_lane_cfg;

    // what one axis lane reports for the current transaction
    typedef struct packed {
        logic             step;
        logic             dir;
        logic [POS_W-1:0] position;
    } t_lane_out;

endpackage

// ----- sv/sdpg_ifs.sv -----
// ----------------------------------------------------------------------------
// sdpg channel interfaces
// valid/ready channels for velocity ticks and step/dir results
// ----------------------------------------------------------------------------
interface sdpg_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] velocity_0;
    logic signed [31:0] velocity_1;
    logic signed [31:0] velocity_2;
    logic signed [31:0] velocity_3;

    modport source (output valid, velocity_0, velocity_1, velocity_2, velocity_3,
                    input ready);
    modport sink   (input valid, velocity_0, velocity_1, velocity_2, velocity_3,
                    output ready);
endinterface

interface sdpg_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  step_pins;
    logic [3:0]  dir_pins;
    logic [31:0] position_0;
    logic [31:0] position_1;
    logic [31:0] position_2;
    logic [31:0] position_3;

    modport source (output valid, step_pins, dir_pins, position_0, position_1,
                    position_2, position_3, input ready);
    modport sink   (input valid, step_pins, dir_pins, position_0, position_1,
                    position_2, position_3, output ready);
endinterface

// ----- sv/sdpg_lane.sv -----
// ----------------------------------------------------------------------------
// sdpg_lane
// one axis: position accumulator, step pulse, direction hold and setup
// ----------------------------------------------------------------------------
module sdpg_lane #(
    parameter int STEP_BIT = sdpg_pkg::STEP_BIT_DEF,
    parameter int COUNT_W  = sdpg_pkg::COUNT_W_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  logic signed [sdpg_pkg::POS_W-1:0] i_velocity,
    input  sdpg_pkg::t_lane_cfg               i_cfg,
    output sdpg_pkg::t_lane_out               o_res
);
    import sdpg_pkg::*;

    logic [POS_W-1:0]   r_acc,   n_acc;
    logic               r_last,  n_last;
    logic [COUNT_W-1:0] r_pulse, n_pulse;
    logic [COUNT_W-1:0] r_setup, n_setup;
    logic [COUNT_W-1:0] r_hold,  n_hold;
    logic               r_dir,   n_dir;

    logic [COUNT_W-1:0] setup_dec;
    logic [COUNT_W-1:0] pulse_ld;
    logic [COUNT_W-1:0] hold_ld;
    logic               step_ready;
    logic               fire;
    logic               vel_neg;
    logic               vel_pos;
    logic               step_on;

    always_comb begin
        setup_dec  = (r_setup != '0) ? r_setup - 1'b1 : '0;
        step_ready = r_acc[STEP_BIT] != r_last;
        vel_neg    = i_velocity[POS_W-1];
        vel_pos    = !vel_neg && (i_velocity != '0);

        // pending step waits out the direction setup with the accumulator frozen
        n_acc = (setup_dec != '0 && step_ready) ? r_acc : r_acc + $unsigned(i_velocity);
        fire  = (setup_dec == '0) && step_ready;

        n_last   = fire ? n_acc[STEP_BIT] : r_last;
        pulse_ld = fire ? i_cfg.step_width[COUNT_W-1:0] : r_pulse;
        hold_ld  = fire ? i_cfg.hold_time[COUNT_W-1:0]  : r_hold;

        n_setup = setup_dec;
        n_dir   = r_dir;
        n_hold  = hold_ld;
        if (hold_ld != '0) begin
            n_hold = hold_ld - 1'b1;
        end else if (vel_pos && r_dir) begin
            n_setup = i_cfg.dir_setup[COUNT_W-1:0];
            n_dir   = 1'b0;
        end else if (vel_neg && !r_dir) begin
            n_setup = i_cfg.dir_setup[COUNT_W-1:0];
            n_dir   = 1'b1;
        end

        step_on = pulse_ld != '0;
        n_pulse = step_on ? pulse_ld - 1'b1 : pulse_ld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_last  <= 1'b0;
            r_pulse <= '0;
            r_setup <= '0;
            r_hold  <= '0;
            r_dir   <= 1'b0;
        end else if (i_adv) begin
            r_acc   <= n_acc;
            r_last  <= n_last;
            r_pulse <= n_pulse;
            r_setup <= n_setup;
            r_hold  <= n_hold;
            r_dir   <= n_dir;
        end
    end

    assign o_res.step     = step_on;
    assign o_res.dir      = n_dir;
    assign o_res.position = n_acc;

endmodule

// ----- sv/sdpg_merge.sv -----
// ----------------------------------------------------------------------------
// sdpg_merge
// packs the lane results into the result register and drives the channel
// ----------------------------------------------------------------------------
module sdpg_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  sdpg_pkg::t_lane_out i_lanes [sdpg_pkg::MAX_AXES],
    output logic                o_can_load,
    sdpg_out_if.source          o_res
);
    import sdpg_pkg::*;

    logic                r_valid;
    logic [MAX_AXES-1:0] r_step;
    logic [MAX_AXES-1:0] r_dir;
    logic [POS_W-1:0]    r_pos [MAX_AXES];
    logic                n_valid;

    // result register frees up in the same cycle its transaction is taken
    assign o_can_load = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int a = 0; a < MAX_AXES; a++) begin
                r_step[a] <= i_lanes[a].step;
                r_dir[a]  <= i_lanes[a].dir;
                r_pos[a]  <= i_lanes[a].position;
            end
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.step_pins  = r_step;
    assign o_res.dir_pins   = r_dir;
    assign o_res.position_0 = r_pos[0];
    assign o_res.position_1 = r_pos[1];
    assign o_res.position_2 = r_pos[2];
    assign o_res.position_3 = r_pos[3];

endmodule

// ----- sv/step_dir_pulse_generator_core.sv -----
// ----------------------------------------------------------------------------
// step_dir_pulse_generator_core
// four-axis step/direction pulse generator driven by per-tick velocities
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying a signed velocity per axis; the
// block answers with exactly one result transaction holding the step and
// direction pin levels and the four position accumulators after that tick.
// One tick is taken every clock cycle unless a result stalls: all axis lanes
// update side by side in the accepting cycle (a 32-bit accumulator add plus
// three 16-bit counters per lane set that path), the result is registered,
// and the output register can be refilled as it is taken. Axes at or above
// AXES read as zero. Timing registers must be written on the plain write
// port while no tick is in flight (unchecked); a write to index 3 is ignored.
// ----------------------------------------------------------------------------
module step_dir_pulse_generator_core #(
    parameter int AXES     = sdpg_pkg::AXES_DEF,
    parameter int STEP_BIT = sdpg_pkg::STEP_BIT_DEF,
    parameter int COUNT_W  = sdpg_pkg::COUNT_W_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sdpg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sdpg_pkg::CFG_W-1:0]     i_cfg_data,
    sdpg_in_if.sink                        i_vel,
    sdpg_out_if.source                     o_res
);
    import sdpg_pkg::*;

    logic [CFG_W-1:0]   r_step_widths;
    logic [CFG_W-1:0]   r_dir_setups;
    logic [CFG_W-1:0]   r_hold_times;

    logic               can_load;
    logic               adv;
    logic signed [POS_W-1:0] vel [MAX_AXES];
    t_lane_out          lanes [MAX_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_widths <= CFG_RESET;
            r_dir_setups  <= CFG_RESET;
            r_hold_times  <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP_WIDTHS: r_step_widths <= i_cfg_data;
                CFG_DIR_SETUPS:  r_dir_setups  <= i_cfg_data;
                CFG_HOLD_TIMES:  r_hold_times  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_vel.ready = can_load;
    assign adv         = i_vel.valid && can_load;

    assign vel[0] = i_vel.velocity_0;
    assign vel[1] = i_vel.velocity_1;
    assign vel[2] = i_vel.velocity_2;
    assign vel[3] = i_vel.velocity_3;

    for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
        if (a < AXES) begin : g_on
            t_lane_cfg lane_cfg;

            assign lane_cfg.step_width = r_step_widths[a*FIELD_W +: FIELD_W];
            assign lane_cfg.dir_setup  = r_dir_setups[a*FIELD_W +: FIELD_W];
            assign lane_cfg.hold_time  = r_hold_times[a*FIELD_W +: FIELD_W];

            sdpg_lane #(
                .STEP_BIT (STEP_BIT),
                .COUNT_W  (COUNT_W)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_adv      (adv),
                .i_velocity (vel[a]),
                .i_cfg      (lane_cfg),
                .o_res      (lanes[a])
            );
        end else begin : g_off
            assign lanes[a] = '0;
        end
    end

    sdpg_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (adv),
        .i_lanes    (lanes),
        .o_can_load (can_load),
        .o_res      (o_res)
    );

    // every accepted tick leaves a result waiting
    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vel.valid && i_vel.ready |=> o_res.valid)
        else $error("accepted tick produced no result");

    // a stalled result must not be overwritten by a new tick
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !(i_vel.valid && i_vel.ready))
        else $error("tick accepted while result stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid straight after reset");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four-axis step/direction pulse generator
// ----------------------------------------------------------------------------
// Velocity ticks go in on a valid/ready channel in random bursts, and results
// are taken out under a changing stall pattern. A cycle-free model of the
// axis lanes predicts each result. Every result is compared field by field
// with the oldest prediction. A short table of hand-picked ticks runs first,
// under the reset timing and then with all timings at zero. Random phases
// follow, each with its own timing setting, written while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;
    import sdpg_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RST_CYCLES    = 8;
    localparam int TIMEOUT_CYC   = 400_000;
    localparam int AXES          = AXES_DEF;
    localparam int STEP_BIT      = STEP_BIT_DEF;
    localparam int COUNT_W       = COUNT_W_DEF;
    localparam int TABLE_ROWS    = 12;
    localparam int RAND_PHASES   = 7;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_AFTER    = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [FIELD_W-1:0]   CNT_MASK  = FIELD_W'((1 << COUNT_W) - 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [31:0] VEL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_MIN  = 32'h8000_0000;
    localparam logic [31:0] STEP_INC = 32'd1 << STEP_BIT;
    localparam logic [31:0] STEP_DEC = -(32'd1 << STEP_BIT);

    typedef logic [MAX_AXES-1:0][POS_W-1:0] t_vel_set;

    typedef struct packed {
        logic [MAX_AXES-1:0]            step;
        logic [MAX_AXES-1:0]            dir;
        logic [MAX_AXES-1:0][POS_W-1:0] pos;
    } t_tick_res;

    typedef struct {
        t_vel_set  vel;
        bit        typed;
        t_tick_res res;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    sdpg_in_if  vin();
    sdpg_out_if vout();

    step_dir_pulse_generator_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_vel      (vin),
        .o_res      (vout)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // mirror of the block's timing registers and lane state
    logic [CFG_W-1:0]   cfg_step_widths;
    logic [CFG_W-1:0]   cfg_dir_setups;
    logic [CFG_W-1:0]   cfg_hold_times;
    logic [POS_W-1:0]   acc       [MAX_AXES];
    logic               last_bit  [MAX_AXES];
    logic [FIELD_W-1:0] pulse_cnt [MAX_AXES];
    logic [FIELD_W-1:0] setup_cnt [MAX_AXES];
    logic [FIELD_W-1:0] hold_cnt  [MAX_AXES];
    logic               dir_neg   [MAX_AXES];

    t_tick_res   pending_results[$];
    t_stim_row   stim_table [TABLE_ROWS];
    logic [31:0] cruise_vel [MAX_AXES];
    int          errors    = 0;
    int          res_seen  = 0;
    int          burst_left = 0;

    function automatic logic [FIELD_W-1:0] lane_of(input logic [CFG_W-1:0] regv, input int a);
        return regv[a*FIELD_W +: FIELD_W] & CNT_MASK;
    endfunction

    function automatic t_tick_res step_axes(input t_vel_set vel);
        t_tick_res r;
        logic      neg;
        logic      pos_v;
        logic      rdy;
        r = '0;
        for (int a = 0; a < MAX_AXES; a++) begin
            if (a < AXES) begin
                neg   = vel[a][31];
                pos_v = !neg && (vel[a] != '0);
                if (setup_cnt[a] != '0) setup_cnt[a] = setup_cnt[a] - 1'b1;
                rdy = (acc[a][STEP_BIT] != last_bit[a]);
                // a pending step waits out the direction setup
                if (!(setup_cnt[a] != '0 && rdy)) acc[a] = acc[a] + vel[a];
                if (setup_cnt[a] == '0 && rdy) begin
                    last_bit[a]  = acc[a][STEP_BIT];
                    pulse_cnt[a] = lane_of(cfg_step_widths, a);
                    hold_cnt[a]  = lane_of(cfg_hold_times, a);
                end
                if (hold_cnt[a] != '0) begin
                    hold_cnt[a] = hold_cnt[a] - 1'b1;
                end else if (pos_v) begin
                    if (dir_neg[a]) begin
                        setup_cnt[a] = lane_of(cfg_dir_setups, a);
                        dir_neg[a]   = 1'b0;
                    end
                end else if (neg) begin
                    if (!dir_neg[a]) begin
                        setup_cnt[a] = lane_of(cfg_dir_setups, a);
                        dir_neg[a]   = 1'b1;
                    end
                end
                if (pulse_cnt[a] != '0) begin
                    pulse_cnt[a] = pulse_cnt[a] - 1'b1;
                    r.step[a]    = 1'b1;
                end
                r.dir[a] = dir_neg[a];
                r.pos[a] = acc[a];
            end
        end
        return r;
    endfunction

    function automatic t_vel_set vels(input logic [31:0] v0, v1, v2, v3);
        return {v3, v2, v1, v0};
    endfunction

    function automatic logic [31:0] pick_velocity(input int a);
        int          sel;
        logic [31:0] mag;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            // steady motion, occasionally a new speed or a reversal
            if ($urandom_range(0, 11) == 0) begin
                mag           = $urandom_range(0, 1 << (STEP_BIT + 1));
                cruise_vel[a] = $urandom_range(0, 1) ? -mag : mag;
            end
            return cruise_vel[a];
        end else if (sel < 72) begin
            return '0;
        end else if (sel < 87) begin
            return $urandom;
        end else if (sel < 95) begin
            case ($urandom_range(0, 6))
                0:       return VEL_MAX;
                1:       return VEL_MIN;
                2:       return 32'd1;
                3:       return 32'hFFFF_FFFF;
                4:       return STEP_INC;
                5:       return STEP_DEC;
                default: return '0;
            endcase
        end
        mag = $urandom_range(0, 3);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic logic [FIELD_W-1:0] pick_lane();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return FIELD_W'($urandom_range(0, 4));
        if (sel < 65) return '0;
        if (sel < 75) return FIELD_W'(1);
        if (sel < 85) return '1;
        return FIELD_W'($urandom);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // the spare index goes last so any decode slip shows in the next phase
    task automatic write_timing(input logic [CFG_W-1:0] widths, setups, holds);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        idx = '{CFG_STEP_WIDTHS, CFG_DIR_SETUPS, CFG_HOLD_TIMES, CFG_SPARE};
        val = '{widths, setups, holds, {$urandom, $urandom}};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
        end
        i_cfg_we        <= 1'b0;
        cfg_step_widths  = widths;
        cfg_dir_setups   = setups;
        cfg_hold_times   = holds;
    endtask

    task automatic wait_drained();
        vin.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                burst_left = 60;
                gap        = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 8);
            end
            if (gap != 0) begin
                vin.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    task automatic send_tick(input t_vel_set v, input bit use_typed, input t_tick_res typed_res);
        t_tick_res pred;
        vin.valid      <= 1'b1;
        vin.velocity_0 <= v[0];
        vin.velocity_1 <= v[1];
        vin.velocity_2 <= v[2];
        vin.velocity_3 <= v[3];
        @(posedge i_clk);
        while (!vin.ready) @(posedge i_clk);
        pred = step_axes(v);
        pending_results.push_back(use_typed ? typed_res : pred);
    endtask

    // result monitor
    always @(posedge i_clk) begin : result_mon
        t_tick_res want;
        if (i_rst_n && vout.valid && vout.ready) begin
            res_seen++;
            if (pending_results.size() == 0) begin
                $error("result transaction with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("step_pins", 32'(want.step), 32'(vout.step_pins));
                check_field("dir_pins", 32'(want.dir), 32'(vout.dir_pins));
                check_field("position_0", want.pos[0], vout.position_0);
                check_field("position_1", want.pos[1], vout.position_1);
                check_field("position_2", want.pos[2], vout.position_2);
                check_field("position_3", want.pos[3], vout.position_3);
            end
        end
    end

    // result receiver: rotating stall patterns plus one long hold-off
    initial begin : result_rx
        int  cyc;
        int  stall_left;
        int  hold_left;
        bit  hold_done;
        logic rdy;
        cyc        = 0;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 0;
        vout.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && res_seen >= HOLD_AFTER) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                rdy       = 1'b0;
            end else begin
                case ((cyc >> 6) % 4)
                    0: rdy = 1'b1;
                    1: rdy = 1'($urandom_range(0, 1));
                    2: rdy = (cyc % 3) != 0;
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            rdy = 1'b0;
                        end else if ($urandom_range(0, 7) == 0) begin
                            stall_left = $urandom_range(1, 6);
                            rdy        = 1'b0;
                        end else begin
                            rdy = 1'b1;
                        end
                    end
                endcase
            end
            vout.ready <= rdy;
            cyc++;
        end
    end

    initial begin : watchdog
        #(TIMEOUT_CYC * 2 * CLK_HALF);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        t_vel_set v;
        logic [CFG_W-1:0] w, s, h;

        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= CFG_STEP_WIDTHS;
        i_cfg_data     <= '0;
        vin.valid      <= 1'b0;
        vin.velocity_0 <= '0;
        vin.velocity_1 <= '0;
        vin.velocity_2 <= '0;
        vin.velocity_3 <= '0;

        cfg_step_widths = CFG_RESET;
        cfg_dir_setups  = CFG_RESET;
        cfg_hold_times  = CFG_RESET;
        for (int a = 0; a < MAX_AXES; a++) begin
            acc[a]        = '0;
            last_bit[a]   = 1'b0;
            pulse_cnt[a]  = '0;
            setup_cnt[a]  = '0;
            hold_cnt[a]   = '0;
            dir_neg[a]    = 1'b0;
            cruise_vel[a] = STEP_INC >> a;
        end

        // first two rows only hold from reset: nothing to step yet, and
        // negative axes turn their direction pins on at once
        stim_table[0]  = '{vels(0, 0, 0, 0), 1'b1, '0};
        stim_table[1]  = '{vels(VEL_MAX, VEL_MIN, 32'd1, 32'hFFFF_FFFF), 1'b1,
                           '{step: 4'b0000, dir: 4'b1010,
                             pos: {32'hFFFF_FFFF, 32'h0000_0001, VEL_MIN, VEL_MAX}}};
        stim_table[2]  = '{vels(STEP_INC, STEP_DEC, 0, STEP_INC), 1'b0, '0};
        stim_table[3]  = '{vels(STEP_INC, STEP_DEC, 0, STEP_DEC), 1'b0, '0};
        stim_table[4]  = '{vels(STEP_DEC, STEP_INC, VEL_MIN, STEP_INC), 1'b0, '0};
        stim_table[5]  = '{vels(STEP_DEC, STEP_INC, VEL_MAX, 0), 1'b0, '0};
        stim_table[6]  = '{vels(0, 0, 32'hFFFF_FFFF, STEP_INC << 1), 1'b0, '0};
        stim_table[7]  = '{vels(STEP_INC >> 1, STEP_DEC >>> 1, 32'd1, STEP_INC), 1'b0, '0};
        stim_table[8]  = '{vels(STEP_INC >> 1, STEP_DEC, STEP_INC, STEP_DEC), 1'b0, '0};
        stim_table[9]  = '{vels(VEL_MIN, VEL_MAX, STEP_DEC, 0), 1'b0, '0};
        stim_table[10] = '{vels(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, STEP_INC),
                           1'b0, '0};
        stim_table[11] = '{vels(0, 0, 0, 0), 1'b0, '0};

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // table under the reset timing, then again with every timing at zero
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                wait_drained();
                write_timing('0, '0, '0);
            end
            for (int r = 0; r < TABLE_ROWS; r++) begin
                pace_sender();
                send_tick(stim_table[r].vel, stim_table[r].typed && pass == 0,
                          stim_table[r].res);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            if (p == 1) begin
                write_timing('1, '1, '1);
            end else if (p == 4) begin
                write_timing(CFG_RESET, CFG_RESET, CFG_RESET);
            end else begin
                for (int a = 0; a < MAX_AXES; a++) begin
                    w[a*FIELD_W +: FIELD_W] = pick_lane();
                    s[a*FIELD_W +: FIELD_W] = pick_lane();
                    h[a*FIELD_W +: FIELD_W] = pick_lane();
                end
                write_timing(w, s, h);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                for (int a = 0; a < MAX_AXES; a++) v[a] = pick_velocity(a);
                pace_sender();
                send_tick(v, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/sdpg_pkg.sv
sv/sdpg_ifs.sv
sv/sdpg_lane.sv
sv/sdpg_merge.sv
sv/step_dir_pulse_generator_core.sv
dv/tb.sv
